/* rtl/core/mono_glyph_to_rgb555_clipped_blit_unit_assert.svh */
// Assertion macros shared by the colour-expand blit RTL.
// Included by the modules that carry concurrent checks; depends on nothing else.
`ifndef MONO_GLYPH_TO_RGB555_CLIPPED_BLIT_UNIT_ASSERT_SVH
`define MONO_GLYPH_TO_RGB555_CLIPPED_BLIT_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MGB_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define MGB_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/mgb_pkg.sv */
// Shared types, constants and helpers for the colour-expand blit.
// Used by the front queue, the pixel expander and the top level.
package mgb_pkg;

   localparam int unsigned FifoDepth      = 4;
   localparam int unsigned FifoPtrWidth   = $clog2(FifoDepth);
   localparam int unsigned FifoCountWidth = FifoPtrWidth + 1;
   localparam logic [FifoCountWidth-1:0] FifoFull = FifoCountWidth'(FifoDepth);

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 24;

   // A whole region row must end at or before this pixel count.
   localparam logic [23:0] RegionPixels = 24'd65536;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_FG_RGB24     = 3'd0,
      CSR_BG_RGB24     = 3'd1,
      CSR_GLYPH_WIDTH  = 3'd2,
      CSR_GLYPH_HEIGHT = 3'd3,
      CSR_REGION_COLS  = 3'd4,
      CSR_REGION_ROWS  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [23:0] fg_rgb24;
      logic [23:0] bg_rgb24;
      logic [10:0] glyph_width;
      logic [10:0] glyph_height;
      logic [11:0] region_cols;
      logic [11:0] region_rows;
   } cfg_type;

   typedef struct packed {
      logic [7:0] raster_byte;
      logic       frame_start;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_type;

   function automatic logic [14:0] to_rgb555(input logic [23:0] rgb);
      return {rgb[23:19], rgb[15:11], rgb[7:3]};
   endfunction

endpackage

/* rtl/core/mgb_req_if.sv */
// Input channel of the colour-expand blit: one raster byte per transfer.
// Stand-alone; no package needed.
interface mgb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] raster_byte;
   logic       frame_start;

   modport source (output valid, raster_byte, frame_start, input ready);
   modport sink (input valid, raster_byte, frame_start, output ready);
endinterface

/* rtl/core/mgb_rsp_if.sv */
// Result channel of the colour-expand blit: one addressed RGB555 pixel per transfer.
// Stand-alone; no package needed.
interface mgb_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] pixel_address;
   logic [15:0] pixel_value;
   logic        run_last;

   modport source (output valid, pixel_address, pixel_value, run_last, input ready);
   modport sink (input valid, pixel_address, pixel_value, run_last, output ready);
endinterface

/* rtl/core/mgb_front.sv */
// Front end of the blit: takes raster bytes and queues them for the expander.
// Depends on mgb_pkg, mgb_req_if and the assertion macro header.
`include "mono_glyph_to_rgb555_clipped_blit_unit_assert.svh"

module mgb_front (
   input  logic               clock,
   input  logic               reset,
   mgb_req_if.sink            req_ch,
   input  logic               pop,
   output mgb_pkg::queue_type head
);
   import mgb_pkg::*;

   item_type                  entry_ff [FifoDepth];
   logic [FifoPtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FifoPtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FifoCountWidth-1:0] count_ff, count_in;
   logic                      push;

   assign req_ch.ready    = (count_ff != FifoFull);
   assign push            = req_ch.valid && req_ch.ready;
   assign head            = '{valid: (count_ff != '0),
                              item:  entry_ff[rd_ptr_ff]};

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + FifoPtrWidth'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + FifoPtrWidth'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + FifoCountWidth'(1);
      end else if (pop && !push) begin
         count_in = count_ff - FifoCountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{raster_byte: req_ch.raster_byte,
                                  frame_start: req_ch.frame_start};
      end
   end

   `MGB_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= FifoFull, "queue overfilled")
   `MGB_ASSERT_IMP(a_pop_nonempty, clock, reset, pop, count_ff != '0, "pop from empty queue")
   `MGB_ASSERT_NXT(a_push_grows, clock, reset, push && !pop, count_ff == $past(count_ff) + FifoCountWidth'(1), "push lost")

endmodule

/* rtl/core/mgb_back.sv */
// Back end of the blit: walks each queued byte one pixel per cycle unless stalled, clips,
// colours and addresses kept pixels. Depends on mgb_pkg, mgb_rsp_if and the macro header.
`include "mono_glyph_to_rgb555_clipped_blit_unit_assert.svh"

module mgb_back (
   input  logic               clock,
   input  logic               reset,
   input  mgb_pkg::cfg_type   cfg,
   input  mgb_pkg::queue_type head,
   output logic               pop,
   mgb_rsp_if.source          rsp_ch
);
   import mgb_pkg::*;

   logic        busy_ff, busy_in;
   logic [7:0]  byte_ff, byte_in;
   logic [2:0]  bit_ff, bit_in;
   logic [10:0] col_ff, col_in;
   logic [10:0] row_ff, row_in;
   logic [15:0] base_ff, base_in;

   logic        hold_vld_ff, hold_vld_in;
   logic        hold_last_ff, hold_last_in;
   logic [15:0] hold_addr_ff, hold_addr_in;
   logic [15:0] hold_val_ff, hold_val_in;

   logic        out_vld_ff, out_vld_in;
   logic        out_last_ff, out_last_in;
   logic [15:0] out_addr_ff, out_addr_in;
   logic [15:0] out_val_ff, out_val_in;

   logic        brk;
   logic [11:0] row_inc;
   logic [23:0] prod;
   logic        keep;
   logic [15:0] pix_addr;
   logic [15:0] pix_val;
   logic        out_free;
   logic        step;
   logic        kept;
   logic        done;
   logic        hold_eff_last;
   logic        out_load;
   logic [10:0] col_next;
   logic        wrap;

   always_comb begin
      brk      = (cfg.glyph_width == '0) || (row_ff >= cfg.glyph_height);
      row_inc  = {1'b0, row_ff} + 12'd1;
      prod     = 24'(row_inc) * 24'(cfg.region_cols);
      keep     = !brk && (col_ff < cfg.glyph_width) && ({1'b0, col_ff} < cfg.region_cols)
                 && ({1'b0, row_ff} < cfg.region_rows) && (prod <= RegionPixels);
      pix_addr = base_ff + 16'(col_ff);
      pix_val  = byte_ff[bit_ff] ? {1'b1, to_rgb555(cfg.fg_rgb24)}
                                 : {1'b0, to_rgb555(cfg.bg_rgb24)};
      out_free = !out_vld_ff || rsp_ch.ready;
      step     = busy_ff && (brk || !keep || !hold_vld_ff || out_free);
      kept     = step && keep;
      done     = step && (brk || (bit_ff == 3'd0));
      hold_eff_last = hold_last_ff || (done && !kept);
      out_load = hold_vld_ff && out_free && (hold_eff_last || kept);
      pop      = head.valid && (!busy_ff || done);
      col_next = col_ff + 11'd1;
      wrap     = (col_next >= cfg.glyph_width);
   end

   always_comb begin
      busy_in = busy_ff;
      byte_in = byte_ff;
      bit_in  = bit_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      base_in = base_ff;
      if (step && !brk) begin
         if (wrap) begin
            col_in  = '0;
            row_in  = row_inc[10:0];
            base_in = (&row_ff) ? '0 : prod[15:0];
         end else begin
            col_in = col_next;
         end
      end
      if (step && !done) begin
         bit_in = bit_ff - 3'd1;
      end
      if (pop) begin
         busy_in = 1'b1;
         byte_in = head.item.raster_byte;
         bit_in  = 3'd7;
         if (head.item.frame_start) begin
            col_in  = '0;
            row_in  = '0;
            base_in = '0;
         end
      end else if (done) begin
         busy_in = 1'b0;
      end
   end

   always_comb begin
      hold_vld_in  = hold_vld_ff;
      hold_last_in = hold_last_ff;
      hold_addr_in = hold_addr_ff;
      hold_val_in  = hold_val_ff;
      if (kept) begin
         hold_vld_in  = 1'b1;
         hold_last_in = done;
         hold_addr_in = pix_addr;
         hold_val_in  = pix_val;
      end else if (out_load) begin
         hold_vld_in = 1'b0;
      end else if (done) begin
         hold_last_in = hold_eff_last;
      end

      out_vld_in  = out_vld_ff;
      out_last_in = out_last_ff;
      out_addr_in = out_addr_ff;
      out_val_in  = out_val_ff;
      if (out_load) begin
         out_vld_in  = 1'b1;
         out_last_in = hold_eff_last;
         out_addr_in = hold_addr_ff;
         out_val_in  = hold_val_ff;
      end else if (rsp_ch.ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         col_ff      <= '0;
         row_ff      <= '0;
         base_ff     <= '0;
         hold_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         base_ff     <= base_in;
         hold_vld_ff <= hold_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      bit_ff       <= bit_in;
      hold_last_ff <= hold_last_in;
      hold_addr_ff <= hold_addr_in;
      hold_val_ff  <= hold_val_in;
      out_last_ff  <= out_last_in;
      out_addr_ff  <= out_addr_in;
      out_val_ff   <= out_val_in;
   end

   assign rsp_ch.valid         = out_vld_ff;
   assign rsp_ch.pixel_address = out_addr_ff;
   assign rsp_ch.pixel_value   = out_val_ff;
   assign rsp_ch.run_last      = out_last_ff;

   `MGB_ASSERT_IMP(a_kept_has_room, clock, reset, kept && hold_vld_ff, out_free, "held pixel overwritten")
   `MGB_ASSERT_IMP(a_idle_no_open_run, clock, reset, !busy_ff, !(hold_vld_ff && !hold_last_ff), "run left open")
   `MGB_ASSERT_NXT(a_frame_restart, clock, reset, pop && head.item.frame_start, (col_ff == '0) && (row_ff == '0) && (base_ff == '0), "frame start missed")

endmodule

/* rtl/core/mono_glyph_to_rgb555_clipped_blit_unit.sv */
// Top level of the monochrome glyph to RGB555 colour-expand blit with clipping.
// Holds the configuration registers; depends on mgb_pkg, both channel interfaces,
// mgb_front and mgb_back.
//
// Usage: raster bytes arrive on req_ch (bit 7 leftmost, rows glyph_width pixels
// long, frame_start returns the position to row 0, column 0 before its byte).
// Every kept pixel leaves on rsp_ch with its region address and RGB555 value;
// run_last marks the last kept pixel of a byte, and a byte may yield none.
// The user writes registers through csr_we, csr_index and csr_wdata only while
// the block is idle, which it does not check; indexes 6 and 7 are ignored.
// A four-entry queue accepts bytes while the expander works. The expander takes
// one pixel position per cycle unless rsp_ch stalls, walking a byte from bit 7 and
// stopping early when the glyph ends inside it or is already finished or empty.
// The row start address comes from one 12 by 12 multiplier in the pixel loop.
// A pixel of a byte passes from the queue entry through the byte register, the
// hold stage and the output register before it reaches rsp_ch.
// Reset clears the queue, the position and the pipeline and restores the
// register defaults. When rsp_ch stalls, one pixel waits in the output register
// and one more in a hold stage; the expander then stops and the queue fills.
module mono_glyph_to_rgb555_clipped_blit_unit (
   input  logic                               clock,
   input  logic                               reset,
   mgb_req_if.sink                            req_ch,
   mgb_rsp_if.source                          rsp_ch,
   input  logic                               csr_we,
   input  logic [mgb_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [mgb_pkg::CsrDataWidth-1:0]   csr_wdata
);
   import mgb_pkg::*;

   logic [23:0] fg_rgb24_ff;
   logic [23:0] bg_rgb24_ff;
   logic [10:0] glyph_width_ff;
   logic [10:0] glyph_height_ff;
   logic [11:0] region_cols_ff;
   logic [11:0] region_rows_ff;
   cfg_type     cfg;
   queue_type   head;
   logic        pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_rgb24_ff     <= 24'hFFFFFF;
         bg_rgb24_ff     <= '0;
         glyph_width_ff  <= '0;
         glyph_height_ff <= '0;
         region_cols_ff  <= 12'd600;
         region_rows_ff  <= 12'd70;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FG_RGB24: begin
               fg_rgb24_ff <= csr_wdata;
            end
            CSR_BG_RGB24: begin
               bg_rgb24_ff <= csr_wdata;
            end
            CSR_GLYPH_WIDTH: begin
               glyph_width_ff <= csr_wdata[10:0];
            end
            CSR_GLYPH_HEIGHT: begin
               glyph_height_ff <= csr_wdata[10:0];
            end
            CSR_REGION_COLS: begin
               region_cols_ff <= csr_wdata[11:0];
            end
            CSR_REGION_ROWS: begin
               region_rows_ff <= csr_wdata[11:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg = '{fg_rgb24:     fg_rgb24_ff,
                  bg_rgb24:     bg_rgb24_ff,
                  glyph_width:  glyph_width_ff,
                  glyph_height: glyph_height_ff,
                  region_cols:  region_cols_ff,
                  region_rows:  region_rows_ff};

   mgb_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .pop    (pop),
      .head   (head)
   );

   mgb_back u_back (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule
